// ===== hdl/mmqs_pkg.sv =====
// Package for the min/max query stack: request and status codes, cell types, defaults.
package mmqs_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_QMAX = 2'd2,
        KIND_QMIN = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] run_max;
        logic signed [DATA_W-1:0] run_min;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctrl;

endpackage

// ===== hdl/mmqs_cell.sv =====
// One stack level: holds an entry with its running extremes, shifts with its neighbors.
module mmqs_cell
    import mmqs_pkg::*;
(
    input  logic        i_clk,
    input  t_shift_ctrl i_ctrl,
    input  t_entry      i_from_upper,
    input  t_entry      i_from_lower,
    output t_entry      o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push) begin
            n_entry = i_from_upper;
        end else if (i_ctrl.pop) begin
            n_entry = i_from_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hdl/min_max_query_stack_core.sv =====
// Top level of the min/max query stack: request decode, fill count and the row of cells.
// Usage:
//   A request transfers at a rising edge with start high and busy low. i_kind picks
//   push, pop, query maximum or query minimum; i_push_value is used by push only.
//   Every request gives one result on o_status / o_answer, marked by o_valid for
//   exactly one cycle, in the cycle after the request transfers.
//   A new request may transfer in every cycle while busy is low: the stack is
//   a row of DEPTH cells, cell 0 being the top; a push shifts every cell down by
//   one level and a pop shifts every cell up, so each request only looks at cell 0.
//   Each cell keeps its value plus the maximum and minimum of itself and all below.
//   Pop or query on an empty stack gives status empty; a push on a full stack is
//   dropped with status full. The answer is zero unless the status is ok.
//   Reset (synchronous, active low) empties the stack; busy is high during reset
//   and in the cycle after it. The receiver cannot stall: each result is
//   taken in the cycle it is shown.
module min_max_query_stack_core
    import mmqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_kind,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_answer
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]         r_fill;
    logic [CNT_W-1:0]         n_fill;
    logic                     r_busy;
    logic                     r_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [DATA_W-1:0] r_answer;
    logic signed [DATA_W-1:0] n_answer;

    logic        accept;
    logic        empty;
    logic        full;
    t_kind       kind;
    t_shift_ctrl ctrl;
    t_entry      new_top;
    t_entry      w_cell [DEPTH];

    assign busy   = r_busy || !i_rst_n;
    assign accept = start && !busy;
    assign empty  = (r_fill == '0);
    assign full   = (r_fill == CNT_W'(DEPTH));
    assign kind   = t_kind'(i_kind);

    always_comb begin
        new_top.value   = i_push_value;
        new_top.run_max = i_push_value;
        new_top.run_min = i_push_value;
        if (!empty) begin
            if (w_cell[0].run_max > i_push_value) begin
                new_top.run_max = w_cell[0].run_max;
            end
            if (w_cell[0].run_min < i_push_value) begin
                new_top.run_min = w_cell[0].run_min;
            end
        end
    end

    always_comb begin
        ctrl     = '0;
        n_fill   = r_fill;
        n_status = ST_OK;
        n_answer = '0;
        case (kind)
            KIND_PUSH: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.push = accept;
                    n_fill    = r_fill + 1'b1;
                end
            end
            KIND_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctrl.pop = accept;
                    n_fill   = r_fill - 1'b1;
                    n_answer = w_cell[0].value;
                end
            end
            KIND_QMAX: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_answer = w_cell[0].run_max;
                end
            end
            KIND_QMIN: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_answer = w_cell[0].run_min;
                end
            end
            default: begin
                n_status = ST_EMPTY;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry from_upper;
            t_entry from_lower;
            if (g == 0) begin : g_top
                assign from_upper = new_top;
            end else begin : g_mid
                assign from_upper = w_cell[g-1];
            end
            if (g == DEPTH - 1) begin : g_bottom
                assign from_lower = '0;
            end else begin : g_above
                assign from_lower = w_cell[g+1];
            end
            mmqs_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_from_upper (from_upper),
                .i_from_lower (from_lower),
                .o_entry      (w_cell[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= accept;
            if (accept) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_answer <= n_answer;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_answer = r_answer;

endmodule
